### design/canonical_min_rotation_assert.svh
// Assertion macros for canonical_min_rotation
`ifndef CANONICAL_MIN_ROTATION_ASSERT_SVH
`define CANONICAL_MIN_ROTATION_ASSERT_SVH
`ifndef SYNTHESIS
`define CMR_ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define CMR_ASSERT_NXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define CMR_ASSERT_IMP(lbl, clk, rst_n, a, c)
`define CMR_ASSERT_NXT(lbl, clk, rst_n, a, c)
`endif
`endif

### design/cmr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cmr_pkg;
	typedef enum logic [3:0] {
		ST_LOAD  = 4'b0001,
		ST_INIT  = 4'b0010,
		ST_CAND  = 4'b0100,
		ST_CMP   = 4'b1000
	} cmr_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;        // store accepted element
		logic init;        // set up search
		logic next_cand;   // start comparing next candidate
		logic cmp_step;    // one compare step
		logic finish;      // latch result, clear counts
	} cmr_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic cand_done;   // no candidates left
		logic cmp_done;    // current compare resolved
		logic search_last; // element accepted is reverse last
	} cmr_stat_t;
endpackage
`default_nettype wire

### design/cmr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "canonical_min_rotation_assert.svh"
module cmr_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_fire,
	input  wire logic              out_fire,
	input  wire cmr_pkg::cmr_stat_t stat,
	output cmr_pkg::cmr_cmd_t      cmd,
	output logic                   in_ready,
	output logic                   out_valid
);
	import cmr_pkg::*;
	cmr_state_t state_q, state_d;
	logic out_valid_q;

	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				cmd.load = in_fire;
				if (in_fire && stat.search_last) state_d = ST_INIT;
			end
			ST_INIT: begin
				cmd.init = 1'b1;
				state_d = ST_CAND;
			end
			ST_CAND: begin
				if (stat.cand_done) begin
					// wait here while the previous result is still held
					if (!out_valid_q || out_fire) begin
						cmd.finish = 1'b1;
						state_d = ST_LOAD;
					end
				end else begin
					cmd.next_cand = 1'b1;
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				cmd.cmp_step = 1'b1;
				if (stat.cmp_done) state_d = ST_CAND;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_LOAD;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.finish) out_valid_q <= 1'b1;
		else if (out_fire) out_valid_q <= 1'b0;
	end

	`CMR_ASSERT_IMP(a_onehot, clk, arst_n, 1'b1, $onehot(state_q))
	`CMR_ASSERT_NXT(a_fin_valid, clk, arst_n, cmd.finish, out_valid)
	`CMR_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_fire, out_valid)
	`CMR_ASSERT_IMP(a_no_clobber, clk, arst_n, cmd.finish, !out_valid || out_fire)
endmodule
`default_nettype wire

### design/cmr_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module cmr_datapath #(
	parameter int MAX_LEN     = 1024,
	parameter int SYMBOL_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmr_pkg::cmr_cmd_t cmd,
	input  wire logic              unrotated_only,
	input  wire logic              in_func,
	input  wire logic [15:0]       in_symbol,
	input  wire logic              in_last,
	output cmr_pkg::cmr_stat_t     stat,
	output logic                   use_reverse,
	output logic [9:0]             rotation,
	output logic [10:0]            min_length,
	output logic                   status
);
	import cmr_pkg::*;
	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CW = $clog2(MAX_LEN + 1);

	logic [SYMBOL_BITS-1:0] fwd_mem [MAX_LEN];
	logic [SYMBOL_BITS-1:0] rev_mem [MAX_LEN];
	logic [CW-1:0] fcnt_q, rcnt_q;
	logic ovf_q;
	logic [11:0] best_q;

	// search state
	logic [CW-1:0] cn_q, bn_q;      // candidate / best lengths
	logic [AW-1:0] cr_q, br_q;      // candidate / best rotations
	logic cdir_q, bdir_q;
	logic [AW-1:0] ci_q, bi_q;      // running read indices
	logic [CW-1:0] k_q;             // compare position
	logic          rd_vld_q;        // read data of previous step valid
	logic [SYMBOL_BITS-1:0] ca_q, cb_q;
	logic          more_q;          // candidates remain
	logic          decided_q;

	wire logic sym_load = cmd.load;
	logic [CW-1:0] flen, rlen;
	assign flen = fcnt_q;
	assign rlen = rcnt_q;

	// element write
	always_ff @(posedge clk) begin
		if (sym_load && !in_func && fcnt_q < CW'(MAX_LEN))
			fwd_mem[fcnt_q[AW-1:0]] <= SYMBOL_BITS'(in_symbol);
		if (sym_load && in_func && rcnt_q < CW'(MAX_LEN))
			rev_mem[rcnt_q[AW-1:0]] <= SYMBOL_BITS'(in_symbol);
	end

	// reads: candidate and best, registered
	always_ff @(posedge clk) begin
		ca_q <= cdir_q ? rev_mem[ci_q] : fwd_mem[ci_q];
		cb_q <= bdir_q ? rev_mem[bi_q] : fwd_mem[bi_q];
	end

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] i, input logic [CW-1:0] n);
		logic [CW-1:0] t;
		t = CW'(i) + CW'(1);
		return (t >= n) ? '0 : t[AW-1:0];
	endfunction

	assign stat.search_last = in_func && in_last;
	assign stat.cand_done = !more_q;
	assign stat.cmp_done = decided_q;

	logic [CW-1:0] ncr;
	assign ncr = CW'(cr_q) + CW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcnt_q <= '0; rcnt_q <= '0; ovf_q <= 1'b0; best_q <= '0;
			more_q <= 1'b0; decided_q <= 1'b0; rd_vld_q <= 1'b0;
			cdir_q <= 1'b0; bdir_q <= 1'b0;
		end else begin
			if (sym_load) begin
				if (!in_func) begin
					if (fcnt_q < CW'(MAX_LEN)) fcnt_q <= fcnt_q + CW'(1);
					else ovf_q <= 1'b1;
				end else begin
					if (rcnt_q < CW'(MAX_LEN)) rcnt_q <= rcnt_q + CW'(1);
					else ovf_q <= 1'b1;
				end
			end
			if (cmd.init) begin
				// best = forward rot 0; first candidate set up by next_cand
				bdir_q <= 1'b0; br_q <= '0; bn_q <= flen;
				if (unrotated_only) begin
					cdir_q <= 1'b1; cr_q <= '0; cn_q <= rlen;
					more_q <= 1'b1;
				end else if (flen > CW'(1)) begin
					cdir_q <= 1'b0; cr_q <= AW'(1); cn_q <= flen; more_q <= 1'b1;
				end else begin
					cdir_q <= 1'b1; cr_q <= '0; cn_q <= rlen;
					more_q <= (rlen != '0);
				end
			end
			if (cmd.next_cand) begin
				ci_q <= cr_q; bi_q <= br_q; k_q <= '0;
				rd_vld_q <= 1'b0;
				decided_q <= (cn_q != bn_q || cn_q == '0);
				if (cn_q < bn_q) begin
					bdir_q <= cdir_q; br_q <= cr_q; bn_q <= cn_q;
				end
			end
			if (cmd.cmp_step && !decided_q) begin
				ci_q <= wrap_inc(ci_q, cn_q);
				bi_q <= wrap_inc(bi_q, bn_q);
				rd_vld_q <= 1'b1;
				if (rd_vld_q) begin
					if (ca_q < cb_q) begin
						bdir_q <= cdir_q; br_q <= cr_q; bn_q <= cn_q;
						decided_q <= 1'b1;
					end else if (ca_q > cb_q || k_q + CW'(1) == cn_q) begin
						decided_q <= 1'b1;
					end
					k_q <= k_q + CW'(1);
				end
			end
			// advance candidate once compare resolves
			if (cmd.cmp_step && decided_q) begin
				if (unrotated_only) more_q <= 1'b0;
				else if (!cdir_q) begin
					if (ncr < flen) cr_q <= ncr[AW-1:0];
					else begin
						cdir_q <= 1'b1; cr_q <= '0; cn_q <= rlen;
						more_q <= (rlen != '0);
					end
				end else begin
					if (ncr < rlen) cr_q <= ncr[AW-1:0];
					else more_q <= 1'b0;
				end
			end
			if (cmd.finish) begin
				best_q <= {bdir_q, 11'(br_q)};
				use_reverse <= bdir_q;
				rotation <= 10'(br_q);
				min_length <= 11'(bn_q);
				status <= ovf_q;
				fcnt_q <= '0; rcnt_q <= '0; ovf_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

### design/canonical_min_rotation.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence: after the reverse last transaction, ST_INIT sets up the search; each candidate then
// passes ST_CAND and ST_CMP (elements compared only if lengths match), then finish sets m_tvalid.
// Throughput: one element per cycle while loading; tready low during the search, and at its
// end while the previous result still waits in m_tdata. Loading resumes once it is latched.
// arst_n clears counts, the overflow flag and state; stores are not cleared.
module canonical_min_rotation #(
	parameter int MAX_LEN     = 1024,
	parameter int SYMBOL_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_data,     // unrotated_only
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,      // symbol
	input  wire logic        s_tuser,      // func
	input  wire logic        s_tlast,      // last
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata       // use_reverse, rotation[10], min_length[11], status, pad
);
	import cmr_pkg::*;
	cmr_cmd_t  cmd;
	cmr_stat_t stat;
	logic ident_q;
	logic ur, st;
	logic [9:0] rot;
	logic [10:0] ml;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ident_q <= 1'b1;
		else if (cfg_valid) ident_q <= cfg_data;
	end

	cmr_ctrl u_ctrl (
		.clk, .arst_n,
		.in_fire(s_tvalid && s_tready),
		.out_fire(m_tvalid && m_tready),
		.stat, .cmd,
		.in_ready(s_tready),
		.out_valid(m_tvalid)
	);

	cmr_datapath #(.MAX_LEN(MAX_LEN), .SYMBOL_BITS(SYMBOL_BITS)) u_dp (
		.clk, .arst_n, .cmd,
		.unrotated_only(ident_q),
		.in_func(s_tuser), .in_symbol(s_tdata), .in_last(s_tlast),
		.stat, .use_reverse(ur), .rotation(rot), .min_length(ml), .status(st)
	);

	assign m_tdata = {1'b0, st, ml, rot, ur};
endmodule
`default_nettype wire
